// ----- design/assert_macros.svh -----
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge, off while reset is high
`define ILS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ils checker: property failed");

// check a property that holds across reset as well
`define ILS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ils checker: property failed");

`endif

// ----- design/ils_pkg.sv -----
// Types and constants of the indexed list store
package ils_pkg;

   localparam int ILS_DEPTH = 64;
   localparam int OP_W      = 3;
   localparam int POS_W     = 7;
   localparam int DATA_W    = 32;
   localparam int CNT_W     = 7;
   localparam int ST_W      = 2;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 3'd0,
      OP_DROP   = 3'd1,
      OP_READ   = 3'd2,
      OP_WRITE  = 3'd3,
      OP_INSERT = 3'd4,
      OP_REMOVE = 3'd5
   } opcode_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_WR,
      S_REM_RD,
      S_REM_WR,
      S_PUT
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

// ----- design/ils_req_if.sv -----
// Request channel of the indexed list store
interface ils_req_if import ils_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          opcode;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] data_in;

   modport source (output valid, opcode, position, data_in, input ready);
   modport sink   (input valid, opcode, position, data_in, output ready);
endinterface

// ----- design/ils_rsp_if.sv -----
// Response channel of the indexed list store
interface ils_rsp_if import ils_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] read_data;
   logic [CNT_W-1:0]         element_count;
   logic [ST_W-1:0]          status;

   modport source (output valid, read_data, element_count, status, input ready);
   modport sink   (input valid, read_data, element_count, status, output ready);
endinterface

// ----- design/ils_store.sv -----
// Entry memory: one write port, one registered read port
module ils_store import ils_pkg::*; #(
   parameter int DEPTH = ILS_DEPTH
) (
   input  logic                       clock,
   input  mem_ctl_type                ctl,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic signed [DATA_W-1:0]   wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic signed [DATA_W-1:0]   rd_data
);

   logic signed [DATA_W-1:0] store_ff [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/indexed_list_store_top.sv -----
// Indexed list store: position-addressed list with a shifting sequencer
// Append, drop last, read, overwrite and every error go from idle straight to
// the response state; insert and remove shift the entries between the position
// and the end of the list, one memory move (read, then write) per entry shifted.
// A response is visible the cycle after the request finishes; a stalled
// response only delays the next finish. Reset empties the list at once.
module indexed_list_store_top import ils_pkg::*; #(
   parameter int DEPTH = ILS_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   ils_req_if.sink    req_bus,
   ils_rsp_if.source  rsp_bus
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > POS_W) ? CW : POS_W;
   localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic [CW-1:0]            pos_ff, pos_in;
   logic signed [DATA_W-1:0] data_ff, data_in;
   logic                     res_rd_ff, res_rd_in;
   status_type               res_st_ff, res_st_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0]         rsp_count_ff, rsp_count_in;
   status_type               rsp_status_ff, rsp_status_in;

   mem_ctl_type              mem_ctl;
   logic [AW-1:0]            wr_addr;
   logic signed [DATA_W-1:0] wr_data;
   logic [AW-1:0]            rd_addr;
   logic signed [DATA_W-1:0] rd_data;

   opcode_type               req_op;
   logic [XW-1:0]            pos_x;
   logic [XW-1:0]            cnt_x;
   logic                     full;
   logic                     empty;
   logic                     ins_mode;
   logic [CW-1:0]            step;
   logic [CW-1:0]            cmp_a;
   logic [CW-1:0]            cmp_b;
   logic                     more;
   logic                     slot_free;

   ils_store #(.DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_op    = opcode_type'(req_bus.opcode);
   assign pos_x     = XW'(req_bus.position);
   assign cnt_x     = XW'(count_ff);
   assign full      = (cnt_x == DEPTH_X);
   assign empty     = (count_ff == '0);
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   // shared step and compare unit of the shift loop
   assign ins_mode = (state_ff == S_INS_RD) || (state_ff == S_INS_WR);
   assign step     = ins_mode ? (idx_ff - CW'(1)) : (idx_ff + CW'(1));
   assign cmp_a    = ins_mode ? pos_ff : step;
   assign cmp_b    = ins_mode ? idx_ff : count_ff;
   assign more     = (cmp_a < cmp_b);

   assign req_bus.ready         = (state_ff == S_IDLE);
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.read_data     = rsp_data_ff;
   assign rsp_bus.element_count = rsp_count_ff;
   assign rsp_bus.status        = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      data_ff       <= data_in;
      res_rd_ff     <= res_rd_in;
      res_st_ff     <= res_st_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      data_in       = data_ff;
      res_rd_in     = res_rd_ff;
      res_st_in     = res_st_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      mem_ctl       = '0;
      wr_addr       = count_ff[AW-1:0];
      wr_data       = req_bus.data_in;
      rd_addr       = pos_x[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               res_rd_in = 1'b0;
               res_st_in = ST_OK;
               state_in  = S_PUT;
               case (req_op)
                  OP_APPEND: begin
                     if (full) begin
                        res_st_in = ST_FULL;
                     end else begin
                        mem_ctl.wr_en = 1'b1;
                        count_in      = count_ff + CW'(1);
                     end
                  end
                  OP_DROP: begin
                     if (empty) begin
                        res_st_in = ST_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  OP_READ: begin
                     if (empty) begin
                        res_st_in = (pos_x == '0) ? ST_EMPTY : ST_RANGE;
                     end else if (pos_x >= cnt_x) begin
                        res_st_in = ST_RANGE;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        res_rd_in     = 1'b1;
                     end
                  end
                  OP_WRITE: begin
                     if (pos_x > cnt_x) begin
                        res_st_in = ST_RANGE;
                     end else if (pos_x == cnt_x) begin
                        if (full) begin
                           res_st_in = ST_FULL;
                        end else begin
                           mem_ctl.wr_en = 1'b1;
                           count_in      = count_ff + CW'(1);
                        end
                     end else begin
                        mem_ctl.wr_en = 1'b1;
                        wr_addr       = pos_x[AW-1:0];
                     end
                  end
                  OP_INSERT: begin
                     if (pos_x > cnt_x) begin
                        res_st_in = ST_RANGE;
                     end else if (full) begin
                        res_st_in = ST_FULL;
                     end else begin
                        idx_in   = count_ff;
                        pos_in   = pos_x[CW-1:0];
                        data_in  = req_bus.data_in;
                        state_in = S_INS_RD;
                     end
                  end
                  OP_REMOVE: begin
                     if (empty) begin
                        res_st_in = ST_EMPTY;
                     end else if (pos_x >= cnt_x) begin
                        res_st_in = ST_RANGE;
                     end else begin
                        idx_in   = pos_x[CW-1:0];
                        state_in = S_REM_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_INS_RD: begin
            if (more) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = step[AW-1:0];
               state_in      = S_INS_WR;
            end else begin
               mem_ctl.wr_en = 1'b1;
               wr_addr       = pos_ff[AW-1:0];
               wr_data       = data_ff;
               count_in      = count_ff + CW'(1);
               state_in      = S_PUT;
            end
         end
         S_INS_WR: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = idx_ff[AW-1:0];
            wr_data       = rd_data;
            idx_in        = step;
            state_in      = S_INS_RD;
         end
         S_REM_RD: begin
            if (more) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = step[AW-1:0];
               state_in      = S_REM_WR;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_PUT;
            end
         end
         S_REM_WR: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = idx_ff[AW-1:0];
            wr_data       = rd_data;
            idx_in        = step;
            state_in      = S_REM_RD;
         end
         S_PUT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_rd_ff ? rd_data : '0;
               rsp_count_in  = cnt_x[CNT_W-1:0];
               rsp_status_in = res_st_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- design/ils_checker.sv -----
// Port-level checker of the indexed list store and its bind
`include "assert_macros.svh"

module ils_checker import ils_pkg::*; #(
   parameter int DEPTH = ILS_DEPTH
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [DATA_W-1:0] rsp_read_data,
   input logic [CNT_W-1:0]         rsp_element_count,
   input logic [ST_W-1:0]          rsp_status
);

   localparam logic [CNT_W-1:0] DEPTH_OUT = CNT_W'(DEPTH);

   `ILS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) && $stable(rsp_status))
   `ILS_ASSERT(a_busy_after_request, clock, reset, req_valid && req_ready |=> !req_ready)
   `ILS_ASSERT(a_error_reads_zero, clock, reset, rsp_valid && rsp_status != ST_OK |-> rsp_read_data == '0)
   `ILS_ASSERT(a_empty_count, clock, reset, rsp_valid && rsp_status == ST_EMPTY |-> rsp_element_count == '0)
   `ILS_ASSERT(a_full_count, clock, reset, rsp_valid && rsp_status == ST_FULL |-> rsp_element_count == DEPTH_OUT)

endmodule

bind indexed_list_store_top ils_checker #(.DEPTH(DEPTH)) u_ils_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_read_data     (rsp_bus.read_data),
   .rsp_element_count (rsp_bus.element_count),
   .rsp_status        (rsp_bus.status)
);
